// File: hdl/edu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// edu_pkg
// Shared types and constants for the Euclidean distance unit.
// ----------------------------------------------------------------------------
package edu_pkg;

	localparam int SUM_W      = 44;                      // Q28.16 running sum
	localparam int DIST_W     = 22;                      // root of the sum, Q14.8
	localparam int ROOT_STEPS = SUM_W / 2;               // one root bit per step
	localparam int STEP_CNT_W = $clog2(ROOT_STEPS);
	localparam int REM_W      = DIST_W + 2;              // partial remainder

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// Commands from the controller to the datapath
	typedef struct packed {
		logic s1_load;    // capture |query - point| of an accepted request
		logic s2_load;    // square the stage-1 magnitude
		logic acc_en;     // add the stage-2 square into the running sum
		logic root_load;  // add the final square, hand the sum to the root unit
		logic root_step;  // produce one more root bit
		logic out_load;   // move the finished root into the output register
	} dp_cmd_t;

endpackage
`default_nettype wire

// File: hdl/edu_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// edu_datapath
// Difference, square, saturating accumulate and bit-serial square root.
// ----------------------------------------------------------------------------
module edu_datapath import edu_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire dp_cmd_t               cmd,
	input  wire logic [COORD_BITS-1:0] query_coord,
	input  wire logic [COORD_BITS-1:0] point_coord,
	output logic      [DIST_W-1:0]     distance,
	output logic                       saturated
);

	localparam int MAG_W = COORD_BITS + 1;
	localparam int SQ_W  = 2 * MAG_W;
	localparam int ACC_W = ((SQ_W > SUM_W) ? SQ_W : SUM_W) + 1;

	logic signed [COORD_BITS:0] diff;
	logic [MAG_W-1:0]           mag;
	logic [MAG_W-1:0]           mag_s1;
	logic [SQ_W-1:0]            sq_s2;
	logic [ACC_W-1:0]           sum_wide;
	logic                       over;
	logic [SUM_W-1:0]           sat_sum;
	logic                       sat_clip;
	logic [SUM_W-1:0]           sum_q;
	logic                       clip_q;
	logic [SUM_W-1:0]           rad_q;
	logic [REM_W-1:0]           rem_q;
	logic [DIST_W-1:0]          root_q;
	logic                       rclip_q;
	logic [REM_W+1:0]           rem_sh;
	logic [REM_W+1:0]           trial;
	logic                       fits;
	logic [REM_W+1:0]           rem_sub;
	logic [DIST_W-1:0]          dist_q;
	logic                       sat_q;

	// Sign-extended difference and its magnitude (2^COORD_BITS still fits)
	assign diff = $signed({query_coord[COORD_BITS-1], query_coord})
	            - $signed({point_coord[COORD_BITS-1], point_coord});
	assign mag  = diff[COORD_BITS] ? MAG_W'(-diff) : MAG_W'(diff);

	// Saturating accumulate
	assign sum_wide = ACC_W'(sum_q) + ACC_W'(sq_s2);
	assign over     = sum_wide > ACC_W'(SUM_MAX);
	assign sat_sum  = over ? SUM_MAX : sum_wide[SUM_W-1:0];
	assign sat_clip = clip_q | over;

	// Restoring root step: bring down two radicand bits, try 4*root + 1
	assign rem_sh  = {rem_q, rad_q[SUM_W-1 -: 2]};
	assign trial   = (REM_W+2)'({root_q, 2'b01});
	assign fits    = rem_sh >= trial;
	assign rem_sub = rem_sh - trial;

	always_ff @(posedge clk) begin
		if (cmd.s1_load) begin
			mag_s1 <= mag;
		end
		if (cmd.s2_load) begin
			sq_s2 <= mag_s1 * mag_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			clip_q <= 1'b0;
		end else if (cmd.root_load) begin
			sum_q  <= '0;
			clip_q <= 1'b0;
		end else if (cmd.acc_en) begin
			sum_q  <= sat_sum;
			clip_q <= sat_clip;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.root_load) begin
			rad_q   <= sat_sum;
			rem_q   <= '0;
			root_q  <= '0;
			rclip_q <= sat_clip;
		end else if (cmd.root_step) begin
			rad_q  <= {rad_q[SUM_W-3:0], 2'b00};
			rem_q  <= fits ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
			root_q <= {root_q[DIST_W-2:0], fits};
		end
		if (cmd.out_load) begin
			dist_q <= root_q;
			sat_q  <= rclip_q;
		end
	end

	assign distance  = dist_q;
	assign saturated = sat_q;

endmodule
`default_nettype wire

// File: hdl/edu_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// edu_ctrl
// Sequencer: stage valids, root step count and output handshake.
// ----------------------------------------------------------------------------
module edu_ctrl import edu_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	input  wire logic s_tlast,
	output logic      s_tready,
	output logic      m_tvalid,
	input  wire logic m_tready,
	output dp_cmd_t   cmd
);

	localparam logic [1:0] ST_RUN   = 2'd0;  // taking requests
	localparam logic [1:0] ST_DRAIN = 2'd1;  // last dimension moving through the pipe
	localparam logic [1:0] ST_ROOT  = 2'd2;  // square root in progress
	localparam logic [1:0] ST_FIN   = 2'd3;  // wait for a free output register

	logic [1:0]            state_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic                  v1_q, l1_q, v2_q, l2_q;
	logic                  out_valid_q;
	logic                  accept;

	assign s_tready = state_q == ST_RUN;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.s1_load   = accept;
		cmd.s2_load   = v1_q;
		cmd.acc_en    = v2_q && !l2_q;
		cmd.root_load = v2_q && l2_q;
		cmd.root_step = state_q == ST_ROOT;
		cmd.out_load  = (state_q == ST_FIN) && (!out_valid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			cnt_q       <= '0;
			v1_q        <= 1'b0;
			l1_q        <= 1'b0;
			v2_q        <= 1'b0;
			l2_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v1_q <= accept;
			l1_q <= accept && s_tlast;
			v2_q <= v1_q;
			l2_q <= l1_q;

			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_RUN: begin
					if (accept && s_tlast) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (cmd.root_load) begin
						state_q <= ST_ROOT;
						cnt_q   <= '0;
					end
				end
				ST_ROOT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == STEP_CNT_W'(ROOT_STEPS - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (cmd.out_load) begin
						state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	// A last dimension closes the input until its root is in the output register
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tlast) |=> !s_tready)
		else $error("request taken after a last dimension");

	// Never overwrite a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || m_tready))
		else $error("output register overwritten");

	// Root load only happens while draining, and starts the root
	a_root_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.root_load |-> (state_q == ST_DRAIN))
		else $error("root load outside drain");

	// Exactly the full number of root steps before finishing
	a_root_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROOT && cnt_q == STEP_CNT_W'(ROOT_STEPS - 1)) |=> (state_q == ST_FIN))
		else $error("root step count wrong");

endmodule
`default_nettype wire

// File: hdl/euclidean_distance_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// euclidean_distance_unit
// Streaming sum of squared differences with a floor square root per point.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (s_*) carries one dimension per request: a query and a
//   point coordinate in signed Q8.8, and s_tlast on the final dimension of a
//   point. The unit squares the difference and adds it to a Q28.16 sum that
//   clamps at its ceiling. On the last dimension it returns one result on the
//   output channel (m_*): the floor square root of the sum as unsigned Q14.8
//   in m_tdata and the clamp flag in m_tuser, then clears the sum.
//   Throughput: one dimension per cycle within a point. After a last
//   dimension the input holds s_tready low through the square stage,
//   the final accumulate, 22 steps of the bit-serial root unit and the load
//   into the output register; m_tvalid rises once that load is done.
//   A waiting result does not block the next point: accumulation goes on and
//   only the next root's hand-off waits for m_tready, holding the input
//   closed until the output register frees up.
//   Reset clears the sum, the clamp flag and all valid state; the unit then
//   takes requests at once.
// ----------------------------------------------------------------------------
module euclidean_distance_unit import edu_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// s_tdata: query_coord [COORD_BITS-1:0], point_coord above it, zero pad
	input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]      s_tdata,
	input  wire logic                                   s_tlast,   // last_dim
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// m_tdata: distance [21:0], zero pad [23:22]
	output logic [((DIST_W+7)/8)*8-1:0]                 m_tdata,
	output logic                                        m_tuser,   // saturated
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready
);

	localparam int OUT_W = ((DIST_W + 7) / 8) * 8;

	dp_cmd_t           cmd;
	logic [DIST_W-1:0] distance;
	logic              saturated;

	// Sequencer: stage valids, root count, output register handshake
	edu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// Arithmetic: |q - p|, square, clamp-add, root, output register
	edu_datapath #(
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.query_coord (s_tdata[COORD_BITS-1:0]),
		.point_coord (s_tdata[2*COORD_BITS-1:COORD_BITS]),
		.distance    (distance),
		.saturated   (saturated)
	);

	// Pad the distance to whole bytes
	assign m_tdata = OUT_W'(distance);
	assign m_tuser = saturated;

endmodule
`default_nettype wire

// File: verif/edu_distance_checker.sv
// ----------------------------------------------------------------------------
// edu_distance_checker
// Watches both stream channels of the distance unit and checks every result
// against a predicted sum of squares and its floor square root.
// ----------------------------------------------------------------------------
module edu_distance_checker import edu_pkg::*; #(
	parameter int COORD_BITS = 16,
	parameter int S_W        = 32,
	parameter int M_W        = 24
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [S_W-1:0] s_tdata,
	input  wire logic           s_tlast,
	input  wire logic           s_tvalid,
	input  wire logic           s_tready,
	input  wire logic [M_W-1:0] m_tdata,
	input  wire logic           m_tuser,
	input  wire logic           m_tvalid,
	input  wire logic           m_tready,
	output int                  fail_count,
	output int                  outstanding,
	output int                  results_seen,
	output int                  clipped_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              saturated;
	} dist_result_t;

	dist_result_t      pending_distances[$];
	logic [SUM_W-1:0]  run_sum;
	logic              run_clipped;

	function automatic longint unsigned diff_square(logic [COORD_BITS-1:0] q,
			logic [COORD_BITS-1:0] p);
		longint d;
		d = longint'($signed(q)) - longint'($signed(p));
		if (d < 0)
			d = -d;
		return longint'(d * d);
	endfunction

	// Bit-by-bit search from the top root bit down.
	function automatic logic [DIST_W-1:0] floor_root(logic [SUM_W-1:0] v);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int b = DIST_W - 1; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= {20'd0, v})
				root = trial;
		end
		return root[DIST_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		longint unsigned sq;
		dist_result_t    want;
		dist_result_t    got;
		if (!arst_n) begin
			run_sum     = '0;
			run_clipped = 1'b0;
			pending_distances.delete();
			fail_count   = 0;
			outstanding  = 0;
			results_seen = 0;
			clipped_seen = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				sq = diff_square(s_tdata[COORD_BITS-1:0], s_tdata[2*COORD_BITS-1:COORD_BITS]);
				// clamp at the ceiling, keep the flag until the point ends
				if (sq > {20'd0, SUM_MAX - run_sum}) begin
					run_sum     = SUM_MAX;
					run_clipped = 1'b1;
				end else begin
					run_sum = run_sum + sq[SUM_W-1:0];
				end
				if (s_tlast) begin
					want.distance  = floor_root(run_sum);
					want.saturated = run_clipped;
					pending_distances.push_back(want);
					run_sum     = '0;
					run_clipped = 1'b0;
				end
			end
			if (m_tvalid && m_tready) begin
				got.distance  = m_tdata[DIST_W-1:0];
				got.saturated = m_tuser;
				results_seen++;
				if (got.saturated)
					clipped_seen++;
				if (pending_distances.size() == 0) begin
					$display("%0t: unexpected result, expected none, got distance %0d saturated %0b",
						$time, got.distance, got.saturated);
					fail_count++;
				end else begin
					want = pending_distances.pop_front();
					if (got.distance !== want.distance) begin
						$display("%0t: distance mismatch, expected %0d, got %0d",
							$time, want.distance, got.distance);
						fail_count++;
					end
					if (got.saturated !== want.saturated) begin
						$display("%0t: saturated mismatch, expected %0b, got %0b",
							$time, want.saturated, got.saturated);
						fail_count++;
					end
				end
			end
			outstanding = pending_distances.size();
		end
	end

endmodule

// File: verif/tb_euclidean_distance_unit.sv
// ----------------------------------------------------------------------------
// tb_euclidean_distance_unit
// Stimulus and verdict for the Euclidean distance unit. Points of random
// length are streamed one dimension per request with random gaps and output
// stalls; a checker beside the block predicts and compares each distance.
// ----------------------------------------------------------------------------
module tb_euclidean_distance_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import edu_pkg::*;

	localparam int     COORD_BITS   = 16;
	localparam int     S_W          = ((2*COORD_BITS+7)/8)*8;
	localparam int     M_W          = ((DIST_W+7)/8)*8;
	localparam int     RESET_CYCLES = 7;
	localparam int     LONG_HOLD    = 300;     // receiver hold-off, in cycles
	localparam int     SETTLE       = 60;      // well past the root latency
	localparam int     RANDOM_DIMS  = 2000;
	// One clamped run of 4097 dims plus ~2000 random dims, each request with a
	// random idle gap, every point blocking the input, every result a long stall.
	localparam longint CYCLE_LIMIT  = 900000;

	localparam logic [15:0] Q_MAX  = 16'h7fff;
	localparam logic [15:0] Q_MIN  = 16'h8000;
	localparam logic [15:0] Q_ZERO = 16'h0000;
	localparam logic [15:0] Q_ONE  = 16'h0001;
	localparam logic [15:0] Q_NEG1 = 16'hffff;

	logic           clk      = 1'b0;
	logic           arst_n   = 1'b0;
	logic [S_W-1:0] s_tdata  = '0;
	logic           s_tlast  = 1'b0;
	logic           s_tvalid = 1'b0;
	logic           m_tready = 1'b0;
	wire  logic           s_tready;
	wire  logic [M_W-1:0] m_tdata;   // distance [21:0], zero pad [23:22]
	wire  logic           m_tuser;   // saturated
	wire  logic           m_tvalid;

	int     fail_count;
	int     outstanding;
	int     results_seen;
	int     clipped_seen;
	int     dims_sent    = 0;
	longint cycle_count  = 0;
	bit     tx_steady    = 1'b0;   // sender offers back to back
	bit     rx_steady    = 1'b0;   // receiver adds no new random stalls
	bit     hold_request = 1'b0;   // ask the receiver for a long hold-off

	euclidean_distance_unit #(
		.COORD_BITS(COORD_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),   // query_coord [15:0], point_coord [31:16]
		.s_tlast (s_tlast),   // last_dim
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tdata (m_tdata),   // distance [21:0], zero pad [23:22]
		.m_tuser (m_tuser),   // saturated
		.m_tvalid(m_tvalid),
		.m_tready(m_tready)
	);

	edu_distance_checker #(
		.COORD_BITS(COORD_BITS),
		.S_W       (S_W),
		.M_W       (M_W)
	) u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.results_seen(results_seen),
		.clipped_seen(clipped_seen)
	);

	always #10 clk = ~clk;

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected",
				cycle_count, outstanding);
			$display("tb_euclidean_distance_unit failed");
			$finish;
		end
	end

	// Idle length: mostly none, often a few cycles, rarely a long stretch.
	function automatic int idle_len();
		int r;
		r = $urandom_range(99, 0);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		if (r < 98)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	// Coordinate shapes: full range, near zero, extremes, or a mix of full range and extremes.
	function automatic logic [15:0] rand_coord(int shape);
		logic [15:0] picks[5];
		picks = '{Q_MAX, Q_MIN, Q_ZERO, Q_ONE, Q_NEG1};
		case (shape)
			0: return 16'($urandom);
			1: return 16'($urandom_range(64, 0) - 32);
			2: return picks[$urandom_range(4, 0)];
			default: return $urandom_range(1, 0) ? 16'($urandom) : picks[$urandom_range(4, 0)];
		endcase
	endfunction

	// Mostly short points, some medium, a few well past a typical run.
	function automatic int point_len();
		int r;
		r = $urandom_range(99, 0);
		if (r < 70)
			return $urandom_range(6, 1);
		if (r < 95)
			return $urandom_range(32, 7);
		return $urandom_range(200, 33);
	endfunction

	// Offer one dimension, hold it until accepted, then idle at random.
	// Entered and left on a falling edge.
	task automatic send_dim(input logic [15:0] q, input logic [15:0] p, input logic last);
		int gap;
		s_tdata  <= S_W'({p, q});
		s_tlast  <= last;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		dims_sent++;
		@(negedge clk);
		gap = tx_steady ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_point(input int dims, input int shape);
		for (int i = 0; i < dims; i++)
			send_dim(rand_coord(shape), rand_coord(shape), i == dims - 1);
	endtask

	// Same pair repeated for a whole point.
	task automatic send_run(input int dims, input logic [15:0] q, input logic [15:0] p);
		for (int i = 0; i < dims; i++)
			send_dim(q, p, i == dims - 1);
	endtask

	// Stop offering until every predicted distance has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	// Receiver: random short stalls, occasionally long ones, and one long
	// hold-off on request while the sender keeps pushing.
	initial begin
		int rx_stall;
		rx_stall = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_request = 1'b0;
				m_tready <= 1'b1;
			end else if (rx_stall > 0) begin
				m_tready <= 1'b0;
				rx_stall--;
			end else if (!rx_steady && $urandom_range(3, 0) == 0) begin
				m_tready <= 1'b0;
				rx_stall = idle_len();
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		int random_start;
		int pt;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: zero, the widest differences in both directions, equal
		// extremes, the smallest nonzero step and alternating bit patterns.
		send_dim(Q_ZERO, Q_ZERO, 1'b1);
		send_dim(Q_MAX, Q_MIN, 1'b1);
		send_dim(Q_MIN, Q_MAX, 1'b1);
		send_dim(Q_MIN, Q_MIN, 1'b1);
		send_dim(Q_ONE, Q_ZERO, 1'b1);
		send_dim(Q_NEG1, Q_ONE, 1'b1);
		send_dim(16'h5555, 16'haaaa, 1'b1);
		send_dim(16'haaaa, 16'h5555, 1'b1);
		// Several dimensions feed one distance; non-last dims give no result.
		send_dim(16'd100, -16'sd50, 1'b0);
		send_dim(-16'sd3, 16'd7, 1'b0);
		send_dim(Q_MAX, Q_ZERO, 1'b0);
		send_dim(Q_ZERO, Q_MIN, 1'b1);
		send_dim(16'h00ff, 16'hff00, 1'b0);
		send_dim(16'h0f0f, 16'hf0f0, 1'b1);

		// One dimension more than the nominal maximum at full scale, which
		// must clamp.
		tx_steady = 1'b1;
		send_run(4097, Q_MIN, Q_MAX);
		tx_steady = 1'b0;
		// Sum and clamp flag must start clean after a clamped point.
		send_dim(Q_ONE, Q_NEG1, 1'b1);
		drain();

		// Random points of random length.
		random_start = dims_sent;
		pt = 0;
		while (dims_sent < random_start + RANDOM_DIMS) begin
			if (pt % 50 == 0) begin
				tx_steady = ($urandom_range(3, 0) == 0);
				rx_steady = ($urandom_range(3, 0) == 0);
			end
			// Fill the block behind a stalled receiver.
			if (pt == 40) begin
				tx_steady    = 1'b1;
				hold_request = 1'b1;
			end
			if (pt == 120)
				drain();
			if (pt % 37 == 0)
				send_run(point_len(), rand_coord(3), rand_coord(3));
			else
				send_point(point_len(), $urandom_range(3, 0));
			pt++;
		end

		drain();
		repeat (SETTLE) @(negedge clk);

		$display("Streamed %0d dimension requests: a clamped full-scale run, %0d random",
			dims_sent, dims_sent - random_start);
		$display("dims with idle gaps both sides, a %0d-cycle output hold-off; %0d distances, %0d clamped.",
			LONG_HOLD, results_seen, clipped_seen);
		if (fail_count == 0 && outstanding == 0) begin
			$display("tb_euclidean_distance_unit passed");
		end else begin
			$display("tb_euclidean_distance_unit failed");
		end
		$finish;
	end

endmodule
